// ----- src/fixed_slot_buffer_pool_defines.svh -----
// Assertion macros shared by the buffer pool RTL.
// Included by the modules that check their own control logic; no other dependencies.
`ifndef FIXED_SLOT_BUFFER_POOL_DEFINES_SVH
`define FIXED_SLOT_BUFFER_POOL_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication: whenever ante holds, cons holds too.
`define FSBP_ASSERT_IMP(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("buffer pool check failed");
// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define FSBP_ASSERT_NXT(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("buffer pool check failed");
`else
`define FSBP_ASSERT_IMP(name, ck, rn, ante, cons)
`define FSBP_ASSERT_NXT(name, ck, rn, ante, cons)
`endif

`endif

// ----- src/fsbp_pkg.sv -----
// Package of the buffer pool: widths, codes, payload structs and the state type.
// Used by the divider and the top level of the pool; depends on nothing.
package fsbp_pkg;

    localparam int MAX_SLOTS   = 256;
    localparam int MIN_SLOTS   = 2;
    localparam int SLOT_W      = $clog2(MAX_SLOTS);
    localparam int ADDR_W      = 32;
    localparam int SIZE_W      = 17;
    localparam int COUNT_W     = 9;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;

    // Slots are a whole number of 64-byte granules.
    localparam int SLOT_GRAIN  = 64;
    localparam int GRAN_SHIFT  = $clog2(SLOT_GRAIN);

    // Serial divider: granule offset divided by slot size in granules.
    localparam int DIV_W       = ADDR_W - GRAN_SHIFT;
    localparam int DIVISOR_W   = SIZE_W - GRAN_SHIFT;
    localparam int REM_W       = DIVISOR_W;
    localparam int STEP_CNT_W  = $clog2(DIV_W);
    localparam int PROD_W      = SLOT_W + DIVISOR_W;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIZE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COUNT = 2'd2;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_TOO_LARGE = 2'd1,
        STATUS_EMPTY     = 2'd2,
        STATUS_BAD_ADDR  = 2'd3
    } fsbp_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ALLOC_SLOT,
        ST_ALLOC_ADDR,
        ST_FREE_DIV
    } fsbp_state_t;

    typedef struct packed {
        logic              cmd;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] address;
    } fsbp_req_t;

    typedef struct packed {
        fsbp_status_t      status;
        logic [ADDR_W-1:0] address_res;
    } fsbp_res_t;

    typedef struct packed {
        logic              done;
        logic              overflow;
        logic [SLOT_W-1:0] quotient;
    } fsbp_div_stat_t;

endpackage

// ----- src/fsbp_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependency.
module fsbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/fsbp_divider.sv -----
// Bit-serial restoring divider: one quotient bit per cycle, for each dividend bit in turn.
// Depends on fsbp_pkg and the assertion macros in fixed_slot_buffer_pool_defines.svh.
`include "fixed_slot_buffer_pool_defines.svh"

module fsbp_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [fsbp_pkg::DIV_W-1:0]     dividend,
    input  logic [fsbp_pkg::DIVISOR_W-1:0] divisor,
    output fsbp_pkg::fsbp_div_stat_t       stat
);
    import fsbp_pkg::*;

    logic [DIV_W-1:0]      dividend_reg, dividend_next;
    logic [DIVISOR_W-1:0]  divisor_reg, divisor_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [SLOT_W-1:0]     quot_reg, quot_next;
    logic                  ovf_reg, ovf_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  run_reg, run_next;
    logic                  done_reg, done_next;

    logic [REM_W:0]        trial;
    logic [REM_W:0]        diff;
    logic                  fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dividend_reg <= dividend_next;
        divisor_reg  <= divisor_next;
        rem_reg      <= rem_next;
        quot_reg     <= quot_next;
        ovf_reg      <= ovf_next;
    end

    // The partial remainder stays below the divisor, so one shifted-in bit
    // makes a trial value one bit wider than the divisor.
    always_comb
    begin
        trial = {rem_reg, dividend_reg[DIV_W-1]};
        fits  = (trial >= {1'b0, divisor_reg});
        diff  = trial - {1'b0, divisor_reg};

        dividend_next = dividend_reg;
        divisor_next  = divisor_reg;
        rem_next      = rem_reg;
        quot_next     = quot_reg;
        ovf_next      = ovf_reg;
        cnt_next      = cnt_reg;
        run_next      = run_reg;
        done_next     = 1'b0;

        if (start)
        begin
            dividend_next = dividend;
            divisor_next  = divisor;
            rem_next      = '0;
            quot_next     = '0;
            ovf_next      = 1'b0;
            cnt_next      = '0;
            run_next      = 1'b1;
        end
        else if (run_reg)
        begin
            dividend_next = {dividend_reg[DIV_W-2:0], 1'b0};
            rem_next      = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
            // Only the low quotient bits are kept; anything above them
            // marks the index as out of range.
            ovf_next      = ovf_reg | quot_reg[SLOT_W-1];
            quot_next     = {quot_reg[SLOT_W-2:0], fits};
            cnt_next      = cnt_reg + 1'b1;
            if (cnt_reg == STEP_CNT_W'(DIV_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign stat.done     = done_reg;
    assign stat.overflow = ovf_reg;
    assign stat.quotient = quot_reg;

    `FSBP_ASSERT_IMP(a_div_step_bound, clk, rst_n, run_reg, cnt_reg < STEP_CNT_W'(DIV_W))
    `FSBP_ASSERT_IMP(a_div_no_restart, clk, rst_n, start, !run_reg)
    `FSBP_ASSERT_NXT(a_div_done_pulse, clk, rst_n, done_reg, !done_reg && !run_reg)

endmodule

// ----- src/fixed_slot_buffer_pool.sv -----
// Top level of the fixed-slot buffer pool: command handshake, free-slot queue, allocator.
// Depends on fsbp_pkg, fsbp_ram, fsbp_divider and fixed_slot_buffer_pool_defines.svh.
//
// Channel    Signals                               Transfer when
// -------    -----------------------------------   ------------------------------
// request    start, busy, request                  start high and busy low
// result     done, result                          done high (one cycle, no stall)
// config     cfg_valid, cfg_ready, cfg_index/data  cfg_valid and cfg_ready high
//
// An allocate that is too large or finds the pool empty, and a free below the base
// address, answer in the cycle after the transfer. A good allocate answers once the
// queue RAM read, the slot times size product and the base add are done in turn. A
// free request answers when the bit-serial divider, which turns the offset into a
// slot index one quotient bit per cycle, is done. Reset is asynchronous and active
// low; it restores the register defaults and refills the queue at once. The receiver
// cannot stall: each result is flagged by done for exactly one cycle.
`include "fixed_slot_buffer_pool_defines.svh"

module fixed_slot_buffer_pool (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  fsbp_pkg::fsbp_req_t               request,
    output logic                              done,
    output fsbp_pkg::fsbp_res_t               result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fsbp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [fsbp_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import fsbp_pkg::*;

    // Slot counts outside the supported range are pinned to its ends.
    function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] raw);
        logic [COUNT_W-1:0] c;
        c = raw;
        if (raw < COUNT_W'(MIN_SLOTS))
        begin
            c = COUNT_W'(MIN_SLOTS);
        end
        else if (raw > COUNT_W'(MAX_SLOTS))
        begin
            c = COUNT_W'(MAX_SLOTS);
        end
        return c;
    endfunction

    fsbp_state_t           state_reg, state_next;
    logic [ADDR_W-1:0]     base_reg, base_next;
    logic [SIZE_W-1:0]     size_reg, size_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [SLOT_W-1:0]     head_reg, head_next;
    logic [SLOT_W-1:0]     tail_reg, tail_next;
    logic [COUNT_W-1:0]    free_count_reg, free_count_next;
    logic [MAX_SLOTS-1:0]  valid_reg, valid_next;
    logic                  done_reg, done_next;
    fsbp_res_t             result_reg, result_next;
    logic                  hit_reg, hit_next;
    logic [SLOT_W-1:0]     slot_hold_reg, slot_hold_next;
    logic [PROD_W-1:0]     product_reg, product_next;

    logic [DIVISOR_W-1:0]  divisor_eff;
    logic [SIZE_W-1:0]     size_bytes;
    logic [COUNT_W-1:0]    count_eff;
    logic [SLOT_W-1:0]     slot_sel;
    logic [SLOT_W:0]       head_inc;
    logic [SLOT_W:0]       tail_inc;
    logic [ADDR_W-1:0]     offset;

    logic                  ram_we;
    logic [SLOT_W-1:0]     ram_rdata;
    logic                  div_start;
    fsbp_div_stat_t        div_stat;

    // The queue RAM holds pushed slot indices. An entry that has not been
    // written since the last refill reads as its own index, which is what a
    // freshly filled queue holds there; the valid bits tell the two apart.
    fsbp_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(MAX_SLOTS)
    ) u_queue (
        .clk  (clk),
        .we   (ram_we),
        .waddr(tail_reg),
        .wdata(div_stat.quotient),
        .raddr(head_reg),
        .rdata(ram_rdata)
    );

    fsbp_divider u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(offset[ADDR_W-1:GRAN_SHIFT]),
        .divisor (divisor_eff),
        .stat    (div_stat)
    );

    // Effective geometry: the slot size is taken in whole granules, with a
    // size below one granule treated as one granule.
    always_comb
    begin
        divisor_eff = size_reg[SIZE_W-1:GRAN_SHIFT];
        if (divisor_eff == '0)
        begin
            divisor_eff = DIVISOR_W'(1);
        end
        size_bytes = {divisor_eff, GRAN_SHIFT'(0)};
        count_eff  = clamp_count(count_reg);
    end

    assign head_inc = {1'b0, head_reg} + 1'b1;
    assign tail_inc = {1'b0, tail_reg} + 1'b1;
    assign offset   = request.address - base_reg;
    assign slot_sel = hit_reg ? ram_rdata : slot_hold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            base_reg       <= '0;
            size_reg       <= SIZE_W'(SLOT_GRAIN);
            count_reg      <= COUNT_W'(MAX_SLOTS);
            head_reg       <= '0;
            tail_reg       <= '0;
            free_count_reg <= COUNT_W'(MAX_SLOTS);
            valid_reg      <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            base_reg       <= base_next;
            size_reg       <= size_next;
            count_reg      <= count_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            free_count_reg <= free_count_next;
            valid_reg      <= valid_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg    <= result_next;
        hit_reg       <= hit_next;
        slot_hold_reg <= slot_hold_next;
        product_reg   <= product_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        base_next       = base_reg;
        size_next       = size_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        free_count_next = free_count_reg;
        valid_next      = valid_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        hit_next        = hit_reg;
        slot_hold_next  = slot_hold_reg;
        product_next    = product_reg;
        ram_we          = 1'b0;
        div_start       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    result_next.address_res = '0;
                    if (request.cmd == CMD_ALLOC)
                    begin
                        // The size check comes before the empty check.
                        if (request.request_size > size_bytes)
                        begin
                            result_next.status = STATUS_TOO_LARGE;
                            done_next          = 1'b1;
                        end
                        else if (free_count_reg == '0)
                        begin
                            result_next.status = STATUS_EMPTY;
                            done_next          = 1'b1;
                        end
                        else
                        begin
                            // Pop: the RAM reads the head entry this cycle.
                            hit_next        = valid_reg[head_reg];
                            slot_hold_next  = head_reg;
                            head_next       = (head_inc == count_eff) ? '0 : head_inc[SLOT_W-1:0];
                            free_count_next = free_count_reg - 1'b1;
                            state_next      = ST_ALLOC_SLOT;
                        end
                    end
                    else
                    begin
                        if (request.address < base_reg)
                        begin
                            result_next.status = STATUS_BAD_ADDR;
                            done_next          = 1'b1;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = ST_FREE_DIV;
                        end
                    end
                end
            end

            ST_ALLOC_SLOT:
            begin
                product_next = PROD_W'(slot_sel) * PROD_W'(divisor_eff);
                state_next   = ST_ALLOC_ADDR;
            end

            ST_ALLOC_ADDR:
            begin
                // Slot address wraps in 32 bits like the address space.
                result_next.status      = STATUS_OK;
                result_next.address_res = base_reg + (ADDR_W'(product_reg) << GRAN_SHIFT);
                done_next               = 1'b1;
                state_next              = ST_IDLE;
            end

            ST_FREE_DIV:
            begin
                if (div_stat.done)
                begin
                    result_next.address_res = '0;
                    if (div_stat.overflow || (COUNT_W'(div_stat.quotient) >= count_eff))
                    begin
                        result_next.status = STATUS_BAD_ADDR;
                    end
                    else
                    begin
                        result_next.status = STATUS_OK;
                        // A push into a full queue is dropped but still reports ok.
                        if (free_count_reg < count_eff)
                        begin
                            ram_we               = 1'b1;
                            valid_next[tail_reg] = 1'b1;
                            tail_next            = (tail_inc == count_eff) ?
                                                   '0 : tail_inc[SLOT_W-1:0];
                            free_count_next      = free_count_reg + 1'b1;
                        end
                    end
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Register writes arrive only while the pool is idle. A new slot count
        // refills the queue at once by dropping all valid bits.
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BASE:
                begin
                    base_next = cfg_data[ADDR_W-1:0];
                end
                CFG_SIZE:
                begin
                    size_next = cfg_data[SIZE_W-1:0];
                end
                CFG_COUNT:
                begin
                    count_next      = cfg_data[COUNT_W-1:0];
                    free_count_next = clamp_count(cfg_data[COUNT_W-1:0]);
                    head_next       = '0;
                    tail_next       = '0;
                    valid_next      = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;

    `FSBP_ASSERT_IMP(a_free_count_bound, clk, rst_n, 1'b1, free_count_reg <= count_eff)
    `FSBP_ASSERT_IMP(a_head_bound, clk, rst_n, 1'b1, COUNT_W'(head_reg) < count_eff)
    `FSBP_ASSERT_IMP(a_tail_bound, clk, rst_n, 1'b1, COUNT_W'(tail_reg) < count_eff)
    `FSBP_ASSERT_NXT(a_accept_progress, clk, rst_n, start && !busy, busy || done)

endmodule
